>>> hdl/usip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usip_pkg
// Shared types, codes and constants of the split interrupt IN poller.
// ----------------------------------------------------------------------------
package usip_pkg;

  localparam int RING_DEPTH  = 16;
  localparam int PTR_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FRAME_W     = 14;
  localparam int REPORT_W    = 64;
  localparam int BYTES_W     = 4;
  localparam int EVENT_W     = 3;
  localparam int ACTION_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int NYET_W      = 6;
  localparam int WAIT_W      = 6;
  localparam int WDOG_W      = 8;

  localparam logic [BYTES_W-1:0] REPORT_BYTES     = 4'd8;
  localparam logic [NYET_W-1:0]  NYET_LIMIT_RESET = 6'd50;
  localparam logic [WAIT_W-1:0]  SPLIT_WAIT_RESET = 6'd8;
  localparam logic [WDOG_W-1:0]  WATCHDOG_RESET   = 8'd5;
  localparam logic [NYET_W-1:0]  NYET_MAX         = 6'd63;
  localparam logic [WDOG_W-1:0]  TICKS_MAX        = 8'd255;

  localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd3;

  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DATA      = 3'd1;
  localparam logic [EVENT_W-1:0] EV_NAK       = 3'd2;
  localparam logic [EVENT_W-1:0] EV_NYET      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ERROR     = 3'd4;
  localparam logic [EVENT_W-1:0] EV_WATCHDOG  = 3'd5;
  localparam logic [EVENT_W-1:0] EV_NOT_READY = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_PRESENT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_MODE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NYET_RETRY_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_WAIT_FRAMES = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WATCHDOG_TICKS    = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_kind;
    logic               start_transfer;
    logic               start_pid;
    logic               reenable_channel;
    logic               complete_split_phase;
    logic               disable_channel;
    logic               report_valid;
  } result_t;

endpackage

>>> hdl/usip_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usip_ring
// Report ring: one synchronous memory with head and tail pointers; pushes
// are dropped when full, pops read through a registered data port.
// ----------------------------------------------------------------------------
module usip_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  usip_pkg::ring_req_t            req,
  input  logic [usip_pkg::REPORT_W-1:0]  report_in,
  output usip_pkg::ring_stat_t           stat,
  output logic [usip_pkg::REPORT_W-1:0]  rd_data
);

  logic [usip_pkg::REPORT_W-1:0] mem [usip_pkg::RING_DEPTH];
  logic [usip_pkg::PTR_W-1:0]    head;
  logic [usip_pkg::PTR_W-1:0]    tail;
  logic [usip_pkg::PTR_W-1:0]    head_next;
  logic [usip_pkg::PTR_W-1:0]    tail_next;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [usip_pkg::PTR_W-1:0] ptr_inc(
    input logic [usip_pkg::PTR_W-1:0] p
  );
    return (p == usip_pkg::PTR_W'(usip_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_next  = ptr_inc(head);
  assign tail_next  = ptr_inc(tail);
  assign stat.empty = (head == tail);
  assign stat.full  = (head_next == tail);
  assign do_push    = accept & req.push & ~stat.full;
  assign do_pop     = accept & req.pop & ~stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[head] <= report_in;
    end
    if (do_pop) begin
      rd_data <= mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (do_push) begin
        head <= head_next;
      end
      if (do_pop) begin
        tail <= tail_next;
      end
    end
  end

endmodule

>>> hdl/usip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usip_ctrl
// Configuration registers, split/toggle/watchdog state and the registered
// result of each accepted beat; issues push and pop requests to the ring.
// ----------------------------------------------------------------------------
module usip_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [usip_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [usip_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              accept,
  input  logic [usip_pkg::ACTION_W-1:0]     action,
  input  logic                              xfer_complete,
  input  logic                              halted,
  input  logic                              got_ack,
  input  logic                              got_nyet,
  input  logic                              got_nak,
  input  logic                              got_error,
  input  logic [usip_pkg::FRAME_W-1:0]      frame_number,
  input  logic [usip_pkg::BYTES_W-1:0]      bytes_remaining,
  input  logic                              channel_active,
  input  usip_pkg::ring_stat_t              ring_stat,
  output usip_pkg::ring_req_t               ring_req,
  output usip_pkg::result_t                 result
);

  logic                          device_present;
  logic                          split_mode;
  logic [usip_pkg::NYET_W-1:0]   nyet_retry_limit;
  logic [usip_pkg::WAIT_W-1:0]   split_wait_frames;
  logic [usip_pkg::WDOG_W-1:0]   watchdog_ticks;

  logic                          data_toggle;
  logic                          in_complete_split;
  logic [usip_pkg::FRAME_W-1:0]  cs_start_frame;
  logic [usip_pkg::NYET_W-1:0]   nyet_count;
  logic                          transfer_pending;
  logic [usip_pkg::WDOG_W-1:0]   ticks_since_start;

  logic                          data_toggle_next;
  logic                          in_complete_split_next;
  logic [usip_pkg::FRAME_W-1:0]  cs_start_frame_next;
  logic [usip_pkg::NYET_W-1:0]   nyet_count_next;
  logic                          transfer_pending_next;
  logic [usip_pkg::WDOG_W-1:0]   ticks_since_start_next;
  usip_pkg::result_t             result_next;

  logic [usip_pkg::FRAME_W-1:0]  frame_delta;
  logic                          waited_enough;
  logic                          has_bytes;
  logic                          restart;
  logic                          handled;
  logic                          want_fresh;

  assign frame_delta   = frame_number - cs_start_frame;
  assign waited_enough = frame_delta >= usip_pkg::FRAME_W'(split_wait_frames);
  assign has_bytes     = bytes_remaining < usip_pkg::REPORT_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_present    <= 1'b0;
      split_mode        <= 1'b0;
      nyet_retry_limit  <= usip_pkg::NYET_LIMIT_RESET;
      split_wait_frames <= usip_pkg::SPLIT_WAIT_RESET;
      watchdog_ticks    <= usip_pkg::WATCHDOG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usip_pkg::REG_DEVICE_PRESENT:    device_present    <= cfg_data[0];
        usip_pkg::REG_SPLIT_MODE:        split_mode        <= cfg_data[0];
        usip_pkg::REG_NYET_RETRY_LIMIT:  nyet_retry_limit  <= cfg_data[usip_pkg::NYET_W-1:0];
        usip_pkg::REG_SPLIT_WAIT_FRAMES: split_wait_frames <= cfg_data[usip_pkg::WAIT_W-1:0];
        usip_pkg::REG_WATCHDOG_TICKS:    watchdog_ticks    <= cfg_data[usip_pkg::WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    data_toggle_next       = data_toggle;
    in_complete_split_next = in_complete_split;
    cs_start_frame_next    = cs_start_frame;
    nyet_count_next        = nyet_count;
    transfer_pending_next  = transfer_pending;
    ticks_since_start_next = ticks_since_start;
    result_next            = '0;
    ring_req               = '0;
    restart                = 1'b0;
    handled                = 1'b0;
    want_fresh             = 1'b0;

    if (!device_present) begin
      result_next.event_kind = usip_pkg::EV_NOT_READY;
    end else begin
      unique case (action)
        usip_pkg::ACT_EVENT: begin
          restart = 1'b1;
          if (xfer_complete) begin
            data_toggle_next = ~data_toggle;
            ring_req.push    = has_bytes;
            if (split_mode) begin
              in_complete_split_next = 1'b0;
            end
            result_next.event_kind = usip_pkg::EV_DATA;
          end else if (halted) begin
            if (split_mode) begin
              if (!in_complete_split && (got_ack || got_nyet)) begin
                in_complete_split_next = 1'b1;
                cs_start_frame_next    = frame_number;
                nyet_count_next        = '0;
                restart                = 1'b0;
                handled                = 1'b1;
              end else if (in_complete_split && got_nyet) begin
                handled = 1'b1;
                if (nyet_count != usip_pkg::NYET_MAX) begin
                  nyet_count_next = nyet_count + 1'b1;
                end
                if (nyet_count_next >= nyet_retry_limit) begin
                  in_complete_split_next = 1'b0;
                  nyet_count_next        = '0;
                  result_next.event_kind = usip_pkg::EV_ERROR;
                end else begin
                  result_next.reenable_channel = waited_enough;
                  result_next.event_kind       = usip_pkg::EV_NYET;
                  restart                      = 1'b0;
                end
              end
              if (!handled) begin
                if (in_complete_split && got_ack) begin
                  data_toggle_next       = ~data_toggle;
                  ring_req.push          = has_bytes;
                  in_complete_split_next = 1'b0;
                  result_next.event_kind = usip_pkg::EV_DATA;
                end else if (got_nak) begin
                  in_complete_split_next = 1'b0;
                  result_next.event_kind = usip_pkg::EV_NAK;
                end else if (got_error) begin
                  in_complete_split_next = 1'b0;
                  result_next.event_kind = usip_pkg::EV_ERROR;
                end
              end
            end else begin
              if (got_ack) begin
                data_toggle_next       = ~data_toggle;
                ring_req.push          = has_bytes;
                result_next.event_kind = usip_pkg::EV_DATA;
              end else if (got_nak) begin
                result_next.event_kind = usip_pkg::EV_NAK;
              end else if (got_error) begin
                result_next.event_kind = usip_pkg::EV_ERROR;
              end
            end
          end
          if (restart) begin
            transfer_pending_next = 1'b0;
            want_fresh            = ~channel_active;
          end
        end
        usip_pkg::ACT_TICK: begin
          if (ticks_since_start != usip_pkg::TICKS_MAX) begin
            ticks_since_start_next = ticks_since_start + 1'b1;
          end
          if (in_complete_split && !channel_active) begin
            result_next.reenable_channel = waited_enough;
          end else if (transfer_pending && ticks_since_start_next >= watchdog_ticks) begin
            result_next.event_kind      = usip_pkg::EV_WATCHDOG;
            result_next.disable_channel = channel_active;
            want_fresh                  = 1'b1;
          end else if (!transfer_pending && !channel_active) begin
            want_fresh = 1'b1;
          end
        end
        usip_pkg::ACT_POP: begin
          ring_req.pop             = 1'b1;
          result_next.report_valid = ~ring_stat.empty;
        end
        usip_pkg::ACT_START: begin
          if (!transfer_pending) begin
            if (channel_active) begin
              result_next.disable_channel = 1'b1;
            end else begin
              want_fresh = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (want_fresh) begin
        transfer_pending_next      = 1'b1;
        ticks_since_start_next     = '0;
        nyet_count_next            = '0;
        cs_start_frame_next        = '0;
        in_complete_split_next     = 1'b0;
        result_next.start_transfer = 1'b1;
        result_next.start_pid      = data_toggle_next;
      end
    end

    result_next.complete_split_phase = in_complete_split_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_toggle       <= 1'b0;
      in_complete_split <= 1'b0;
      cs_start_frame    <= '0;
      nyet_count        <= '0;
      transfer_pending  <= 1'b0;
      ticks_since_start <= '0;
    end else if (accept) begin
      data_toggle       <= data_toggle_next;
      in_complete_split <= in_complete_split_next;
      cs_start_frame    <= cs_start_frame_next;
      nyet_count        <= nyet_count_next;
      transfer_pending  <= transfer_pending_next;
      ticks_since_start <= ticks_since_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

>>> hdl/usb_split_interrupt_in_poller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_split_interrupt_in_poller
// Interrupt IN poller for one 8-byte HID pipe with split transactions,
// data toggle, NYET limit, deferred complete-split, watchdog and report ring.
// ----------------------------------------------------------------------------
//  channel  handshake                beat
//  in       in_valid / in_ready      action, status flags, frame, bytes, report
//  out      out_valid / out_ready    event, start/pid, reenable, phase, report
//  cfg      cfg_we (no wait)         cfg_index, cfg_data
//
// one beat per cycle; each result appears in the cycle after its input beat,
// held in the output register with the ring's registered read port
// a new input beat is taken whenever the output register is empty or being
// drained in the same cycle
// report ring memory has undefined contents after reset; no clearing pass
// synchronous active-high reset clears pointers, state and configuration
module usb_split_interrupt_in_poller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [usip_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [usip_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [usip_pkg::ACTION_W-1:0]     action,
  input  logic                              xfer_complete,
  input  logic                              halted,
  input  logic                              got_ack,
  input  logic                              got_nyet,
  input  logic                              got_nak,
  input  logic                              got_error,
  input  logic [usip_pkg::FRAME_W-1:0]      frame_number,
  input  logic [usip_pkg::BYTES_W-1:0]      bytes_remaining,
  input  logic [usip_pkg::REPORT_W-1:0]     report_in,
  input  logic                              channel_active,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [usip_pkg::EVENT_W-1:0]      event_kind,
  output logic                              start_transfer,
  output logic                              start_pid,
  output logic                              reenable_channel,
  output logic                              complete_split_phase,
  output logic                              disable_channel,
  output logic                              report_valid,
  output logic [usip_pkg::REPORT_W-1:0]     report_out
);

  logic                           accept;
  usip_pkg::ring_req_t            ring_req;
  usip_pkg::ring_stat_t           ring_stat;
  usip_pkg::result_t              result;
  logic [usip_pkg::REPORT_W-1:0]  rd_data;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  usip_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .action          (action),
    .xfer_complete   (xfer_complete),
    .halted          (halted),
    .got_ack         (got_ack),
    .got_nyet        (got_nyet),
    .got_nak         (got_nak),
    .got_error       (got_error),
    .frame_number    (frame_number),
    .bytes_remaining (bytes_remaining),
    .channel_active  (channel_active),
    .ring_stat       (ring_stat),
    .ring_req        (ring_req),
    .result          (result)
  );

  usip_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (ring_req),
    .report_in (report_in),
    .stat      (ring_stat),
    .rd_data   (rd_data)
  );

  assign event_kind           = result.event_kind;
  assign start_transfer       = result.start_transfer;
  assign start_pid            = result.start_pid;
  assign reenable_channel     = result.reenable_channel;
  assign complete_split_phase = result.complete_split_phase;
  assign disable_channel      = result.disable_channel;
  assign report_valid         = result.report_valid;
  assign report_out           = result.report_valid ? rd_data : '0;

endmodule

>>> hdl/usip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usip_checker
// Port-level checks of the split interrupt IN poller, bound to the top level.
// ----------------------------------------------------------------------------
module usip_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [usip_pkg::EVENT_W-1:0]      event_kind,
  input logic                              start_transfer,
  input logic                              start_pid,
  input logic                              report_valid,
  input logic [usip_pkg::REPORT_W-1:0]     report_out
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(report_out))
    else $error("result beat changed while stalled");

  // never refuses input with an empty output register
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while output register empty");

  // pid only accompanies a started transfer
  a_pid_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_pid |-> start_transfer)
    else $error("start pid without start transfer");

  // no report data without a popped report
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> report_out == '0)
    else $error("report data without report valid");

  // a popped report never comes with a status event
  a_pop_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> event_kind == usip_pkg::EV_NONE && !start_transfer)
    else $error("popped report with event or start");

endmodule

bind usb_split_interrupt_in_poller usip_checker u_usip_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .start_transfer (start_transfer),
  .start_pid      (start_pid),
  .report_valid   (report_valid),
  .report_out     (report_out)
);

>>> tb/usip_poll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usip_poll_checker
// Watches the config port and both channels of the split interrupt IN poller.
// Every input beat is run through a cycle-free model of the poller state
// (toggle, split phase, NYET count, watchdog, report ring) and the outcome is
// queued; each output beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module usip_poll_checker
  import usip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [ACTION_W-1:0]    action,
  input  logic                   xfer_complete,
  input  logic                   halted,
  input  logic                   got_ack,
  input  logic                   got_nyet,
  input  logic                   got_nak,
  input  logic                   got_error,
  input  logic [FRAME_W-1:0]     frame_number,
  input  logic [BYTES_W-1:0]     bytes_remaining,
  input  logic [REPORT_W-1:0]    report_in,
  input  logic                   channel_active,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [EVENT_W-1:0]     event_kind,
  input  logic                   start_transfer,
  input  logic                   start_pid,
  input  logic                   reenable_channel,
  input  logic                   complete_split_phase,
  input  logic                   disable_channel,
  input  logic                   report_valid,
  input  logic [REPORT_W-1:0]    report_out,
  output int                     fail_count,
  output int                     owed
);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                xfer_complete;
    logic                halted;
    logic                got_ack;
    logic                got_nyet;
    logic                got_nak;
    logic                got_error;
    logic [FRAME_W-1:0]  frame;
    logic [BYTES_W-1:0]  bytes;
    logic [REPORT_W-1:0] report;
    logic                active;
  } poll_beat_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_kind;
    logic                start_transfer;
    logic                start_pid;
    logic                reenable_channel;
    logic                complete_split_phase;
    logic                disable_channel;
    logic                report_valid;
    logic [REPORT_W-1:0] report;
  } poll_result_t;

  logic                present_q;
  logic                split_q;
  logic [NYET_W-1:0]   nyet_limit_q;
  logic [WAIT_W-1:0]   wait_frames_q;
  logic [WDOG_W-1:0]   wdog_limit_q;

  logic                toggle_q;
  logic                in_cs_q;
  logic [FRAME_W-1:0]  cs_frame_q;
  logic [NYET_W-1:0]   nyet_cnt_q;
  logic                pending_q;
  logic [WDOG_W-1:0]   ticks_q;
  logic [REPORT_W-1:0] report_ring [RING_DEPTH];
  int                  ring_wr;
  int                  ring_rd;

  poll_result_t        due_results [$];

  function automatic logic cs_wait_over(input logic [FRAME_W-1:0] frame);
    logic [FRAME_W-1:0] gap;
    gap = frame - cs_frame_q;
    return gap >= wait_frames_q;
  endfunction

  function automatic void store_report(input logic [REPORT_W-1:0] rep,
                                       input logic [BYTES_W-1:0] left);
    int nxt;
    if (left >= REPORT_BYTES) return;
    nxt = (ring_wr + 1) % RING_DEPTH;
    if (nxt != ring_rd) begin
      report_ring[ring_wr] = rep;
      ring_wr = nxt;
    end
  endfunction

  function automatic logic begin_transfer(input logic active);
    if (active) return 1'b0;
    pending_q  = 1'b1;
    ticks_q    = '0;
    nyet_cnt_q = '0;
    cs_frame_q = '0;
    in_cs_q    = 1'b0;
    return 1'b1;
  endfunction

  function automatic poll_result_t next_poll_result(input poll_beat_t b);
    poll_result_t r;
    logic         restart;
    logic         handled;
    logic         started;
    r       = '0;
    started = 1'b0;
    if (!present_q) begin
      r.event_kind = EV_NOT_READY;
    end else begin
      case (b.action)
        ACT_EVENT: begin
          restart = 1'b1;
          handled = 1'b0;
          if (b.xfer_complete) begin
            toggle_q = ~toggle_q;
            store_report(b.report, b.bytes);
            if (split_q) in_cs_q = 1'b0;
            r.event_kind = EV_DATA;
          end else if (b.halted && split_q) begin
            if (!in_cs_q && (b.got_ack || b.got_nyet)) begin
              in_cs_q    = 1'b1;
              cs_frame_q = b.frame;
              nyet_cnt_q = '0;
              restart    = 1'b0;
              handled    = 1'b1;
            end else if (in_cs_q && b.got_nyet) begin
              if (nyet_cnt_q != NYET_MAX) nyet_cnt_q = nyet_cnt_q + 1'b1;
              handled = 1'b1;
              if (nyet_cnt_q >= nyet_limit_q) begin
                in_cs_q      = 1'b0;
                nyet_cnt_q   = '0;
                r.event_kind = EV_ERROR;
              end else begin
                r.reenable_channel = cs_wait_over(b.frame);
                r.event_kind       = EV_NYET;
                restart            = 1'b0;
              end
            end
            if (!handled) begin
              if (in_cs_q && b.got_ack) begin
                toggle_q = ~toggle_q;
                store_report(b.report, b.bytes);
                in_cs_q      = 1'b0;
                r.event_kind = EV_DATA;
              end else if (b.got_nak) begin
                in_cs_q      = 1'b0;
                r.event_kind = EV_NAK;
              end else if (b.got_error) begin
                in_cs_q      = 1'b0;
                r.event_kind = EV_ERROR;
              end
            end
          end else if (b.halted) begin
            if (b.got_ack) begin
              toggle_q = ~toggle_q;
              store_report(b.report, b.bytes);
              r.event_kind = EV_DATA;
            end else if (b.got_nak) begin
              r.event_kind = EV_NAK;
            end else if (b.got_error) begin
              r.event_kind = EV_ERROR;
            end
          end
          if (restart) begin
            pending_q = 1'b0;
            started   = begin_transfer(b.active);
          end
        end
        ACT_TICK: begin
          if (ticks_q != TICKS_MAX) ticks_q = ticks_q + 1'b1;
          if (in_cs_q && !b.active) begin
            r.reenable_channel = cs_wait_over(b.frame);
          end else if (pending_q && ticks_q >= wdog_limit_q) begin
            r.event_kind      = EV_WATCHDOG;
            r.disable_channel = b.active;
            started           = begin_transfer(1'b0);
          end else if (!pending_q && !b.active) begin
            started = begin_transfer(1'b0);
          end
        end
        ACT_POP: begin
          if (ring_wr != ring_rd) begin
            r.report_valid = 1'b1;
            r.report       = report_ring[ring_rd];
            ring_rd        = (ring_rd + 1) % RING_DEPTH;
          end
        end
        ACT_START: begin
          if (!pending_q) begin
            if (b.active) r.disable_channel = 1'b1;
            else started = begin_transfer(1'b0);
          end
        end
      endcase
    end
    if (started) begin
      r.start_transfer = 1'b1;
      r.start_pid      = toggle_q;
    end
    r.complete_split_phase = in_cs_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [REPORT_W-1:0] want,
                                      input logic [REPORT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    poll_result_t want;
    poll_beat_t   beat;
    if (rst) begin
      present_q     = 1'b0;
      split_q       = 1'b0;
      nyet_limit_q  = NYET_LIMIT_RESET;
      wait_frames_q = SPLIT_WAIT_RESET;
      wdog_limit_q  = WATCHDOG_RESET;
      toggle_q      = 1'b0;
      in_cs_q       = 1'b0;
      cs_frame_q    = '0;
      nyet_cnt_q    = '0;
      pending_q     = 1'b0;
      ticks_q       = '0;
      ring_wr       = 0;
      ring_rd       = 0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_PRESENT:    present_q     = cfg_data[0];
          REG_SPLIT_MODE:        split_q       = cfg_data[0];
          REG_NYET_RETRY_LIMIT:  nyet_limit_q  = cfg_data[NYET_W-1:0];
          REG_SPLIT_WAIT_FRAMES: wait_frames_q = cfg_data[WAIT_W-1:0];
          REG_WATCHDOG_TICKS:    wdog_limit_q  = cfg_data[WDOG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat: expected none actual event_kind %0d",
                   $time, event_kind);
        end else begin
          want = due_results.pop_front();
          check_field("event_kind", want.event_kind, event_kind);
          check_field("start_transfer", want.start_transfer, start_transfer);
          check_field("start_pid", want.start_pid, start_pid);
          check_field("reenable_channel", want.reenable_channel, reenable_channel);
          check_field("complete_split_phase", want.complete_split_phase, complete_split_phase);
          check_field("disable_channel", want.disable_channel, disable_channel);
          check_field("report_valid", want.report_valid, report_valid);
          check_field("report_out", want.report, report_out);
        end
      end
      if (in_valid && in_ready) begin
        beat.action        = action;
        beat.xfer_complete = xfer_complete;
        beat.halted        = halted;
        beat.got_ack       = got_ack;
        beat.got_nyet      = got_nyet;
        beat.got_nak       = got_nak;
        beat.got_error     = got_error;
        beat.frame         = frame_number;
        beat.bytes         = bytes_remaining;
        beat.report        = report_in;
        beat.active        = channel_active;
        due_results.push_back(next_poll_result(beat));
      end
    end
    owed <= due_results.size();
  end

endmodule

>>> tb/usb_split_interrupt_in_poller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_split_interrupt_in_poller_test
// Drives the poller through a directed pass over each action and split case,
// then random phases of well-formed split and plain exchanges mixed with
// ticks, pops and noise, under several register settings. Input beats come in
// bursts, the result side stalls on its own patterns; the checker scores.
// ----------------------------------------------------------------------------
module usb_split_interrupt_in_poller_test;
  import usip_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // xfer_complete, halted, ack, nyet, nak, error
  localparam logic [5:0] FL_NONE = 6'b000000;
  localparam logic [5:0] FL_XC   = 6'b100000;
  localparam logic [5:0] FL_HALT = 6'b010000;
  localparam logic [5:0] FL_ACK  = 6'b001000;
  localparam logic [5:0] FL_NYET = 6'b000100;
  localparam logic [5:0] FL_NAK  = 6'b000010;
  localparam logic [5:0] FL_ERR  = 6'b000001;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [5:0]          flags;
    logic [FRAME_W-1:0]  frame;
    logic [BYTES_W-1:0]  bytes;
    logic [REPORT_W-1:0] report;
    logic                active;
  } stim_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [ACTION_W-1:0]    action;
  logic                   xfer_complete;
  logic                   halted;
  logic                   got_ack;
  logic                   got_nyet;
  logic                   got_nak;
  logic                   got_error;
  logic [FRAME_W-1:0]     frame_number;
  logic [BYTES_W-1:0]     bytes_remaining;
  logic [REPORT_W-1:0]    report_in;
  logic                   channel_active;
  logic                   out_valid;
  logic                   out_ready;
  logic [EVENT_W-1:0]     event_kind;
  logic                   start_transfer;
  logic                   start_pid;
  logic                   reenable_channel;
  logic                   complete_split_phase;
  logic                   disable_channel;
  logic                   report_valid;
  logic [REPORT_W-1:0]    report_out;

  int                     fail_count;
  int                     owed;
  int                     in_beats;
  int                     quiet_cycles;
  logic [FRAME_W-1:0]     frame_now;
  stim_beat_t             beat_q [$];

  usb_split_interrupt_in_poller i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .action               (action),
    .xfer_complete        (xfer_complete),
    .halted               (halted),
    .got_ack              (got_ack),
    .got_nyet             (got_nyet),
    .got_nak              (got_nak),
    .got_error            (got_error),
    .frame_number         (frame_number),
    .bytes_remaining      (bytes_remaining),
    .report_in            (report_in),
    .channel_active       (channel_active),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .event_kind           (event_kind),
    .start_transfer       (start_transfer),
    .start_pid            (start_pid),
    .reenable_channel     (reenable_channel),
    .complete_split_phase (complete_split_phase),
    .disable_channel      (disable_channel),
    .report_valid         (report_valid),
    .report_out           (report_out)
  );

  usip_poll_checker i_poll_checker (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .action               (action),
    .xfer_complete        (xfer_complete),
    .halted               (halted),
    .got_ack              (got_ack),
    .got_nyet             (got_nyet),
    .got_nak              (got_nak),
    .got_error            (got_error),
    .frame_number         (frame_number),
    .bytes_remaining      (bytes_remaining),
    .report_in            (report_in),
    .channel_active       (channel_active),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .event_kind           (event_kind),
    .start_transfer       (start_transfer),
    .start_pid            (start_pid),
    .reenable_channel     (reenable_channel),
    .complete_split_phase (complete_split_phase),
    .disable_channel      (disable_channel),
    .report_valid         (report_valid),
    .report_out           (report_out),
    .fail_count           (fail_count),
    .owed                 (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) in_beats <= 0;
    else if (in_valid && in_ready) in_beats <= in_beats + 1;
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stretches of full rate, coin flips, a fixed pattern and
  // light stalls, plus two long hold-offs so the block backs up into its input
  initial begin
    int mode;
    int run;
    int holds;
    int phase;
    holds = 0;
    phase = 0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (holds < 2 && in_beats >= 300 + 500 * holds) begin
        holds++;
        out_ready <= 1'b0;
        repeat (64) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 40);
      repeat (run) begin
        phase++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= (phase % 3 == 0);
          default: out_ready <= ($urandom_range(0, 5) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic void step_frame();
    if ($urandom_range(0, 49) == 0) frame_now = FRAME_W'($urandom);
    else frame_now = frame_now + FRAME_W'($urandom_range(0, 20));
  endfunction

  function automatic stim_beat_t make_beat(input logic [ACTION_W-1:0] act,
                                           input logic [5:0] flags, input logic active);
    stim_beat_t b;
    b.action = act;
    b.flags  = flags;
    b.frame  = frame_now;
    b.bytes  = ($urandom_range(0, 3) == 0) ? BYTES_W'($urandom_range(0, 15)) : '0;
    b.report = {$urandom, $urandom};
    b.active = active;
    return b;
  endfunction

  function automatic void directed(input logic [ACTION_W-1:0] act, input logic [5:0] flags,
                                   input logic active, input logic [BYTES_W-1:0] bytes,
                                   input logic [REPORT_W-1:0] report);
    stim_beat_t b;
    b        = make_beat(act, flags, active);
    b.bytes  = bytes;
    b.report = report;
    beat_q.push_back(b);
  endfunction

  function automatic void add_split_exchange();
    int nyets;
    nyets = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
    beat_q.push_back(make_beat(ACT_START, FL_NONE, 1'b0));
    step_frame();
    beat_q.push_back(make_beat(ACT_EVENT,
                               FL_HALT | (($urandom_range(0, 1) == 1) ? FL_ACK : FL_NYET),
                               1'b0));
    for (int i = 0; i < nyets; i++) begin
      step_frame();
      if ($urandom_range(0, 4) == 0)
        beat_q.push_back(make_beat(ACT_TICK, FL_NONE, ($urandom_range(0, 3) == 0)));
      beat_q.push_back(make_beat(ACT_EVENT, FL_HALT | FL_NYET, 1'b0));
    end
    step_frame();
    case ($urandom_range(0, 5))
      0, 1, 2: beat_q.push_back(make_beat(ACT_EVENT, FL_HALT | FL_ACK, 1'b0));
      3:       beat_q.push_back(make_beat(ACT_EVENT, FL_XC, 1'b0));
      4:       beat_q.push_back(make_beat(ACT_EVENT, FL_HALT | FL_NAK, 1'b0));
      default: beat_q.push_back(make_beat(ACT_EVENT, FL_HALT | FL_ERR, 1'b0));
    endcase
  endfunction

  function automatic void add_plain_exchange();
    logic [5:0] flags;
    case ($urandom_range(0, 5))
      0, 1:    flags = FL_HALT | FL_ACK;
      2:       flags = FL_XC;
      3:       flags = FL_HALT | FL_NAK;
      4:       flags = FL_HALT | FL_ERR;
      default: flags = FL_HALT;
    endcase
    beat_q.push_back(make_beat(ACT_START, FL_NONE, ($urandom_range(0, 7) == 0)));
    step_frame();
    beat_q.push_back(make_beat(ACT_EVENT, flags, ($urandom_range(0, 7) == 0)));
  endfunction

  function automatic void build_random(input int count, input int pop_pct);
    int pick;
    while (beat_q.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < pop_pct) begin
        repeat ($urandom_range(1, 4)) beat_q.push_back(make_beat(ACT_POP, FL_NONE, 1'b0));
      end else if (pick < pop_pct + 10) begin
        beat_q.push_back(make_beat(ACTION_W'($urandom_range(0, 3)), 6'($urandom),
                                   1'($urandom)));
      end else if (pick < pop_pct + 20) begin
        repeat ($urandom_range(1, 8)) begin
          step_frame();
          beat_q.push_back(make_beat(ACT_TICK, FL_NONE, ($urandom_range(0, 3) == 0)));
        end
      end else if (pick < pop_pct + 60) begin
        add_split_exchange();
      end else begin
        add_plain_exchange();
      end
    end
  endfunction

  task automatic send_beats();
    stim_beat_t b;
    int         burst;
    int         gap;
    burst = 0;
    while (beat_q.size() != 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      b = beat_q.pop_front();
      action          <= b.action;
      {xfer_complete, halted, got_ack, got_nyet, got_nak, got_error} <= b.flags;
      frame_number    <= b.frame;
      bytes_remaining <= b.bytes;
      report_in       <= b.report;
      channel_active  <= b.active;
      in_valid        <= 1'b1;
      do @(posedge clk); while (!in_ready);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic present, input logic split, input int limit,
                              input int split_wait, input int wdog);
    write_reg(REG_DEVICE_PRESENT, {7'($urandom), present});
    write_reg(REG_SPLIT_MODE, {7'($urandom), split});
    write_reg(REG_NYET_RETRY_LIMIT, {2'($urandom), 6'(limit)});
    write_reg(REG_SPLIT_WAIT_FRAMES, {2'($urandom), 6'(split_wait)});
    write_reg(REG_WATCHDOG_TICKS, 8'(wdog));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic present, input logic split, input int limit,
                           input int split_wait, input int wdog, input int count,
                           input int pop_pct);
    program_regs(present, split, limit, split_wait, wdog);
    build_random(count, pop_pct);
    send_beats();
    drain();
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    action          <= ACT_EVENT;
    {xfer_complete, halted, got_ack, got_nyet, got_nak, got_error} <= FL_NONE;
    frame_number    <= '0;
    bytes_remaining <= '0;
    report_in       <= '0;
    channel_active  <= 1'b0;
    frame_now = FRAME_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // device absent after reset
    directed(ACT_EVENT, FL_HALT | FL_ACK, 1'b0, '0, '1);
    directed(ACT_TICK, FL_NONE, 1'b0, '0, '0);
    directed(ACT_POP, FL_NONE, 1'b0, '0, '0);
    directed(ACT_START, FL_NONE, 1'b0, '0, '0);
    send_beats();
    drain();

    // plain transfers with reset limits
    program_regs(1'b1, 1'b0, NYET_LIMIT_RESET, SPLIT_WAIT_RESET, WATCHDOG_RESET);
    frame_now = '0;
    directed(ACT_START, FL_NONE, 1'b0, '0, '0);
    directed(ACT_EVENT, FL_HALT | FL_ACK, 1'b0, '0, '1);
    directed(ACT_START, FL_NONE, 1'b0, '0, '0);
    directed(ACT_EVENT, FL_XC, 1'b0, REPORT_BYTES, '1);
    directed(ACT_EVENT, FL_XC, 1'b0, '1, '1);
    directed(ACT_EVENT, FL_HALT, 1'b0, '0, '0);
    directed(ACT_EVENT, FL_HALT | FL_NAK, 1'b1, '0, '0);
    directed(ACT_START, FL_NONE, 1'b1, '0, '0);
    repeat (5) directed(ACT_TICK, FL_NONE, 1'b0, '0, '0);
    directed(ACT_TICK, FL_NONE, 1'b1, '0, '0);
    directed(ACT_EVENT, FL_HALT | FL_ERR, 1'b0, '0, '0);
    repeat (2) directed(ACT_POP, FL_NONE, 1'b0, '0, '0);
    send_beats();
    drain();

    // split phases across the frame wrap
    program_regs(1'b1, 1'b1, NYET_LIMIT_RESET, SPLIT_WAIT_RESET, WATCHDOG_RESET);
    frame_now = '1;
    directed(ACT_EVENT, FL_HALT | FL_ACK, 1'b0, '0, '0);
    frame_now = FRAME_W'(2);
    directed(ACT_EVENT, FL_HALT | FL_NYET, 1'b0, '0, '0);
    frame_now = FRAME_W'(8);
    directed(ACT_TICK, FL_NONE, 1'b0, '0, '0);
    directed(ACT_EVENT, FL_HALT | FL_ACK, 1'b0, '0, {$urandom, $urandom});
    directed(ACT_EVENT, FL_HALT | FL_NYET, 1'b0, '0, '0);
    directed(ACT_EVENT, FL_HALT | FL_NAK, 1'b0, '0, '0);
    directed(ACT_POP, FL_NONE, 1'b0, '0, '0);
    send_beats();
    drain();

    run_phase(1'b1, 1'b0, 50, 8, 5, 250, 25);
    run_phase(1'b1, 1'b1, 63, 63, 255, 250, 5);
    run_phase(1'b1, 1'b1, 1, 0, 1, 220, 30);
    run_phase(1'b1, 1'b1, 0, 0, 0, 200, 25);
    run_phase(1'b0, 1'b1, $urandom_range(1, 62), $urandom_range(1, 62),
              $urandom_range(1, 254), 40, 20);
    run_phase(1'b1, 1'b1, $urandom_range(1, 62), $urandom_range(1, 62),
              $urandom_range(1, 254), 250, 15);
    run_phase(1'b1, 1'b0, $urandom_range(1, 62), $urandom_range(1, 62),
              $urandom_range(1, 254), 220, 10);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/usip_pkg.sv
hdl/usip_ring.sv
hdl/usip_ctrl.sv
hdl/usb_split_interrupt_in_poller.sv
hdl/usip_checker.sv
tb/usip_poll_checker.sv
tb/usb_split_interrupt_in_poller_test.sv
